>>> sv/greedy_nearest_assignment_unit_assert.svh
// Assertion macros for the greedy nearest assignment unit.
`ifndef GREEDY_NEAREST_ASSIGNMENT_UNIT_ASSERT_SVH
`define GREEDY_NEAREST_ASSIGNMENT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GNA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gna: implication check failed");
`define GNA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gna: next-cycle check failed");
`else
`define GNA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GNA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/gna_pkg.sv
`timescale 1ns / 1ps
package gna_pkg;

    localparam int MAX_ROBOTS_DEF = 16;
    localparam int MAX_JOBS_DEF   = 16;
    localparam int COORD_BITS_DEF = 24;

    localparam int SLOT_W = 4;
    localparam int JOB_W  = 31;
    localparam int POS_W  = 24;
    localparam int DIST_W = 50;
    localparam int DATA_W = 88;

    typedef enum logic [1:0] {
        KIND_LOAD_ROBOT = 2'd0,
        KIND_LOAD_JOB   = 2'd1,
        KIND_SOLVE      = 2'd2,
        KIND_CLEAR      = 2'd3
    } t_kind;

    typedef struct packed {
        logic load_robot;
        logic load_job;
        logic clear_all;
        logic solve_init;
        logic round_start;
        logic issue;
        logic emit_pair;
        logic emit_empty;
    } t_cmd;

    typedef struct packed {
        logic free_r_nz;
        logic free_j_nz;
        logic pipe_busy;
        logic out_free;
        logic last_next;
    } t_status;

endpackage

>>> sv/greedy_nearest_assignment_unit.sv
// Load and clear words are accepted back to back.
// A solve emits P pairs; each costs a scan of all MAX_ROBOTS*MAX_JOBS slot pairs through the
// four-stage distance pipeline, a drain and an emit (first pair: a check step before).
// A solve with no possible pair gives a single result, registered from the check state once the output is free.
// Input is held off until the last result of a solve is registered.
// Reset empties all slots; stored positions and identifiers stay undefined until loaded.
`timescale 1ns / 1ps
`include "greedy_nearest_assignment_unit_assert.svh"
module greedy_nearest_assignment_unit #(
    parameter int MAX_ROBOTS = gna_pkg::MAX_ROBOTS_DEF,
    parameter int MAX_JOBS   = gna_pkg::MAX_JOBS_DEF,
    parameter int COORD_BITS = gna_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // slot[3:0], job_id[34:4], pos_x[58:35], pos_y[82:59], zero fill
    input  logic [gna_pkg::DATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  logic [1:0]                  i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // robot_slot[3:0], assigned_job[34:4], dist_sq[84:35], zero fill
    output logic [gna_pkg::DATA_W-1:0]  o_m_tdata,
    // pair_valid[0]
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);
    localparam int RB = MAX_ROBOTS > 1 ? $clog2(MAX_ROBOTS) : 1;
    localparam int JB = MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1;

    gna_pkg::t_cmd    w_cmd;
    gna_pkg::t_status w_status;
    logic [RB-1:0]    w_rob_idx;
    logic [JB-1:0]    w_job_idx;
    logic [gna_pkg::SLOT_W-1:0] w_robot_slot;
    logic [gna_pkg::JOB_W-1:0]  w_assigned_job;
    logic [gna_pkg::DIST_W-1:0] w_dist_sq;

    gna_ctrl #(
        .MAX_ROBOTS(MAX_ROBOTS),
        .MAX_JOBS  (MAX_JOBS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_rob_idx  (w_rob_idx),
        .o_job_idx  (w_job_idx)
    );

    gna_dp #(
        .MAX_ROBOTS(MAX_ROBOTS),
        .MAX_JOBS  (MAX_JOBS),
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_rob_idx      (w_rob_idx),
        .i_job_idx      (w_job_idx),
        .i_slot         (i_s_tdata[3:0]),
        .i_job_id       (i_s_tdata[34:4]),
        .i_pos_x        (i_s_tdata[58:35]),
        .i_pos_y        (i_s_tdata[82:59]),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_pair_valid   (o_m_tuser),
        .o_robot_slot   (w_robot_slot),
        .o_assigned_job (w_assigned_job),
        .o_dist_sq      (w_dist_sq),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, w_dist_sq, w_assigned_job, w_robot_slot};

    `GNA_ASSERT_IMP(a_empty_is_last, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tlast)
    `GNA_ASSERT_IMP(a_empty_is_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == '0)
    `GNA_ASSERT_NXT(a_solve_blocks, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (i_s_tuser == gna_pkg::KIND_SOLVE), !o_s_tready)

endmodule

>>> sv/gna_ctrl.sv
`timescale 1ns / 1ps
module gna_ctrl #(
    parameter int MAX_ROBOTS = gna_pkg::MAX_ROBOTS_DEF,
    parameter int MAX_JOBS   = gna_pkg::MAX_JOBS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_kind,
    output logic               o_in_ready,
    input  gna_pkg::t_status   i_status,
    output gna_pkg::t_cmd      o_cmd,
    output logic [(MAX_ROBOTS > 1 ? $clog2(MAX_ROBOTS) : 1)-1:0] o_rob_idx,
    output logic [(MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1)-1:0]     o_job_idx
);
    localparam int RB = MAX_ROBOTS > 1 ? $clog2(MAX_ROBOTS) : 1;
    localparam int JB = MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [RB-1:0] r_ri, n_ri;
    logic [JB-1:0] r_ji, n_ji;

    always_comb begin
        n_state    = r_state;
        n_ri       = r_ri;
        n_ji       = r_ji;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (gna_pkg::t_kind'(i_kind))
                        gna_pkg::KIND_LOAD_ROBOT: o_cmd.load_robot = 1'b1;
                        gna_pkg::KIND_LOAD_JOB:   o_cmd.load_job = 1'b1;
                        gna_pkg::KIND_CLEAR:      o_cmd.clear_all = 1'b1;
                        gna_pkg::KIND_SOLVE: begin
                            o_cmd.solve_init = 1'b1;
                            n_state = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_status.free_r_nz && i_status.free_j_nz) begin
                    o_cmd.round_start = 1'b1;
                    n_ri = '0;
                    n_ji = '0;
                    n_state = S_SCAN;
                end else if (i_status.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (r_ji == JB'(MAX_JOBS - 1)) begin
                    n_ji = '0;
                    if (r_ri == RB'(MAX_ROBOTS - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_ri = r_ri + 1'b1;
                    end
                end else begin
                    n_ji = r_ji + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_pair = 1'b1;
                    if (i_status.last_next) begin
                        n_state = S_IDLE;
                    end else begin
                        // free pairs remain: start the next round
                        o_cmd.round_start = 1'b1;
                        n_ri = '0;
                        n_ji = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ri    <= '0;
            r_ji    <= '0;
        end else begin
            r_state <= n_state;
            r_ri    <= n_ri;
            r_ji    <= n_ji;
        end
    end

    assign o_rob_idx = r_ri;
    assign o_job_idx = r_ji;

endmodule

>>> sv/gna_dp.sv
`timescale 1ns / 1ps
module gna_dp #(
    parameter int MAX_ROBOTS = gna_pkg::MAX_ROBOTS_DEF,
    parameter int MAX_JOBS   = gna_pkg::MAX_JOBS_DEF,
    parameter int COORD_BITS = gna_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gna_pkg::t_cmd                 i_cmd,
    output gna_pkg::t_status              o_status,
    input  logic [(MAX_ROBOTS > 1 ? $clog2(MAX_ROBOTS) : 1)-1:0] i_rob_idx,
    input  logic [(MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1)-1:0]     i_job_idx,
    input  logic [gna_pkg::SLOT_W-1:0]    i_slot,
    input  logic [gna_pkg::JOB_W-1:0]     i_job_id,
    input  logic [gna_pkg::POS_W-1:0]     i_pos_x,
    input  logic [gna_pkg::POS_W-1:0]     i_pos_y,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_pair_valid,
    output logic [gna_pkg::SLOT_W-1:0]    o_robot_slot,
    output logic [gna_pkg::JOB_W-1:0]     o_assigned_job,
    output logic [gna_pkg::DIST_W-1:0]    o_dist_sq,
    output logic                          o_last
);
    localparam int RB = MAX_ROBOTS > 1 ? $clog2(MAX_ROBOTS) : 1;
    localparam int JB = MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1;
    localparam int CB = COORD_BITS;
    localparam int SW = 2 * CB + 3;

    logic [CB-1:0] r_rob_px [MAX_ROBOTS];
    logic [CB-1:0] r_rob_py [MAX_ROBOTS];
    logic [CB-1:0] r_job_px [MAX_JOBS];
    logic [CB-1:0] r_job_py [MAX_JOBS];
    logic [gna_pkg::JOB_W-1:0] r_job_id [MAX_JOBS];

    logic [MAX_ROBOTS-1:0] r_rob_present, r_free_r;
    logic [MAX_JOBS-1:0]   r_job_present, r_free_j;

    logic [RB-1:0] w_rob_waddr;
    logic [JB-1:0] w_job_waddr;
    logic          w_rob_wen, w_job_wen;

    assign w_rob_waddr = RB'(i_slot);
    assign w_job_waddr = JB'(i_slot);
    assign w_rob_wen   = i_cmd.load_robot && (int'(i_slot) < MAX_ROBOTS);
    assign w_job_wen   = i_cmd.load_job && (int'(i_slot) < MAX_JOBS);

    always_ff @(posedge i_clk) begin
        if (w_rob_wen) begin
            r_rob_px[w_rob_waddr] <= CB'(i_pos_x);
            r_rob_py[w_rob_waddr] <= CB'(i_pos_y);
        end
        if (w_job_wen) begin
            r_job_px[w_job_waddr] <= CB'(i_pos_x);
            r_job_py[w_job_waddr] <= CB'(i_pos_y);
            r_job_id[w_job_waddr] <= i_job_id;
        end
    end

    // pipeline: read, difference magnitude, square, compare
    logic                      r_v1, r_v2, r_v3;
    logic [RB-1:0]             r_r1, r_r2, r_r3;
    logic [JB-1:0]             r_j1, r_j2, r_j3;
    logic [gna_pkg::JOB_W-1:0] r_id1, r_id2, r_id3;
    logic [CB-1:0]             r_px1, r_py1, r_jx1, r_jy1;
    logic [CB:0]               r_mx2, r_my2;
    logic [2*CB+1:0]           r_sx3, r_sy3;
    logic signed [CB:0]        w_dx, w_dy;
    logic [SW-1:0]             w_sum;
    logic                      w_issue_v;

    assign w_issue_v = i_cmd.issue && r_free_r[i_rob_idx] && r_free_j[i_job_idx];
    assign w_dx = $signed({r_px1[CB-1], r_px1}) - $signed({r_jx1[CB-1], r_jx1});
    assign w_dy = $signed({r_py1[CB-1], r_py1}) - $signed({r_jy1[CB-1], r_jy1});
    assign w_sum = SW'(r_sx3) + SW'(r_sy3);

    always_ff @(posedge i_clk) begin
        r_px1 <= r_rob_px[i_rob_idx];
        r_py1 <= r_rob_py[i_rob_idx];
        r_jx1 <= r_job_px[i_job_idx];
        r_jy1 <= r_job_py[i_job_idx];
        r_id1 <= r_job_id[i_job_idx];
        r_r1  <= i_rob_idx;
        r_j1  <= i_job_idx;
        r_mx2 <= w_dx[CB] ? (CB + 1)'(-w_dx) : (CB + 1)'(w_dx);
        r_my2 <= w_dy[CB] ? (CB + 1)'(-w_dy) : (CB + 1)'(w_dy);
        r_r2  <= r_r1;
        r_j2  <= r_j1;
        r_id2 <= r_id1;
        r_sx3 <= r_mx2 * r_mx2;
        r_sy3 <= r_my2 * r_my2;
        r_r3  <= r_r2;
        r_j3  <= r_j2;
        r_id3 <= r_id2;
    end

    logic [SW-1:0]             r_best_d;
    logic [RB-1:0]             r_best_r;
    logic [JB-1:0]             r_best_j;
    logic [gna_pkg::JOB_W-1:0] r_best_id;
    logic                      r_found;

    // strict less-than keeps the earlier pair on ties
    always_ff @(posedge i_clk) begin
        if (r_v3 && (!r_found || w_sum < r_best_d)) begin
            r_best_d  <= w_sum;
            r_best_r  <= r_r3;
            r_best_j  <= r_j3;
            r_best_id <= r_id3;
        end
    end

    logic [MAX_ROBOTS-1:0] w_rem_r;
    logic [MAX_JOBS-1:0]   w_rem_j;
    assign w_rem_r = r_free_r & ~(MAX_ROBOTS'(1) << r_best_r);
    assign w_rem_j = r_free_j & ~(MAX_JOBS'(1) << r_best_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rob_present <= '0;
            r_job_present <= '0;
            r_free_r      <= '0;
            r_free_j      <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_found       <= 1'b0;
            o_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_rob_present <= '0;
                r_job_present <= '0;
            end
            if (w_rob_wen) r_rob_present[w_rob_waddr] <= 1'b1;
            if (w_job_wen) r_job_present[w_job_waddr] <= 1'b1;
            if (i_cmd.solve_init) begin
                r_free_r <= r_rob_present;
                r_free_j <= r_job_present;
            end else if (i_cmd.emit_pair) begin
                r_free_r <= w_rem_r;
                r_free_j <= w_rem_j;
            end
            r_v1 <= w_issue_v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.round_start) begin
                r_found <= 1'b0;
            end else if (r_v3) begin
                r_found <= 1'b1;
            end
            if (i_cmd.emit_pair || i_cmd.emit_empty) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pair) begin
            o_pair_valid   <= 1'b1;
            o_robot_slot   <= gna_pkg::SLOT_W'(r_best_r);
            o_assigned_job <= r_best_id;
            o_dist_sq      <= gna_pkg::DIST_W'(r_best_d);
            o_last         <= (w_rem_r == '0) || (w_rem_j == '0);
        end else if (i_cmd.emit_empty) begin
            o_pair_valid   <= 1'b0;
            o_robot_slot   <= '0;
            o_assigned_job <= '0;
            o_dist_sq      <= '0;
            o_last         <= 1'b1;
        end
    end

    assign o_status.free_r_nz = (r_free_r != '0);
    assign o_status.free_j_nz = (r_free_j != '0);
    assign o_status.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_status.out_free  = !o_out_valid || i_out_ready;
    assign o_status.last_next = (w_rem_r == '0) || (w_rem_j == '0);

endmodule

>>> bench/greedy_nearest_assignment_unit_tb.sv
`timescale 1ns / 1ps
module greedy_nearest_assignment_unit_tb;

    localparam int NR = 16;
    localparam int NJ = 16;

    typedef struct packed {
        logic        pair_valid;
        logic [3:0]  robot_slot;
        logic [30:0] assigned_job;
        logic [49:0] dist_sq;
        logic        last;
    } t_pair;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [gna_pkg::DATA_W-1:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [gna_pkg::DATA_W-1:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    greedy_nearest_assignment_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    // Shadow of the slot contents
    logic signed [23:0] rob_x [NR];
    logic signed [23:0] rob_y [NR];
    logic [NR-1:0]      rob_here;
    logic signed [23:0] ord_x [NJ];
    logic signed [23:0] ord_y [NJ];
    logic [30:0]        ord_id [NJ];
    logic [NJ-1:0]      ord_here;

    t_pair pending_pairs [$];
    int    errors = 0;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    solves_sent;
    int    pairs_seen = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [49:0] dist_between(int r, int j);
        logic signed [49:0] dx;
        logic signed [49:0] dy;
        dx = 50'(rob_x[r]) - 50'(ord_x[j]);
        dy = 50'(rob_y[r]) - 50'(ord_y[j]);
        return 50'(dx * dx) + 50'(dy * dy);
    endfunction

    function automatic void queue_pair(t_pair p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    // Greedy pairing: closest free pair each round, lower robot then lower order on ties
    function automatic void predict_assignment();
        logic [NR-1:0] free_r;
        logic [NJ-1:0] free_j;
        logic [49:0]   best;
        logic [49:0]   d;
        int            br;
        int            bj;
        int            n;
        bit            found;
        t_pair         p;
        free_r = rob_here;
        free_j = ord_here;
        n = 0;
        forever begin
            found = 1'b0;
            best = '0;
            br = 0;
            bj = 0;
            for (int r = 0; r < NR; r++) begin
                for (int j = 0; j < NJ; j++) begin
                    if (free_r[r] && free_j[j]) begin
                        d = dist_between(r, j);
                        if (!found || d < best) begin
                            found = 1'b1;
                            best = d;
                            br = r;
                            bj = j;
                        end
                    end
                end
            end
            if (!found) break;
            p = '{1'b1, 4'(br), ord_id[bj], best, 1'b0};
            queue_pair(p);
            n++;
            free_r[br] = 1'b0;
            free_j[bj] = 1'b0;
        end
        if (n == 0) begin
            p = '{1'b0, 4'd0, 31'd0, 50'd0, 1'b1};
            queue_pair(p);
        end else begin
            pending_pairs[$].last = 1'b1;
        end
    endfunction

    task automatic send_word(gna_pkg::t_kind kind, logic [3:0] slot, logic [30:0] job,
                             logic [23:0] px, logic [23:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {5'd0, py, px, job, slot};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        case (kind)
            gna_pkg::KIND_LOAD_ROBOT: begin
                rob_x[slot] = px;
                rob_y[slot] = py;
                rob_here[slot] = 1'b1;
            end
            gna_pkg::KIND_LOAD_JOB: begin
                ord_x[slot] = px;
                ord_y[slot] = py;
                ord_id[slot] = job;
                ord_here[slot] = 1'b1;
            end
            gna_pkg::KIND_CLEAR: begin
                rob_here = '0;
                ord_here = '0;
            end
            default: begin
                predict_assignment();
                solves_sent++;
            end
        endcase
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(9))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2, 3: return 24'($urandom_range(255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_pair got;
        t_pair want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tuser, o_m_tdata[3:0], o_m_tdata[34:4], o_m_tdata[84:35], o_m_tlast};
            pairs_seen++;
            if (pending_pairs.size() == 0) begin
                $error("unexpected word: robot_slot %0d", got.robot_slot);
                errors++;
            end else begin
                want = pending_pairs.pop_front();
                if (got.pair_valid !== want.pair_valid) begin
                    $error("pair_valid: expected %0d, got %0d", want.pair_valid, got.pair_valid);
                    errors++;
                end
                if (got.robot_slot !== want.robot_slot) begin
                    $error("robot_slot: expected %0d, got %0d", want.robot_slot, got.robot_slot);
                    errors++;
                end
                if (got.assigned_job !== want.assigned_job) begin
                    $error("assigned_job: expected %0d, got %0d",
                           want.assigned_job, got.assigned_job);
                    errors++;
                end
                if (got.dist_sq !== want.dist_sq) begin
                    $error("dist_sq: expected %0d, got %0d", want.dist_sq, got.dist_sq);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_solve();
        send_word(gna_pkg::KIND_SOLVE, 4'd0, 31'd0, 24'd0, 24'd0);
        // robots only, still no pair
        send_word(gna_pkg::KIND_LOAD_ROBOT, 4'd15, 31'h7fffffff, 24'h800000, 24'h7fffff);
        send_word(gna_pkg::KIND_SOLVE, 4'hf, 31'h7fffffff, 24'hffffff, 24'hffffff);
        send_word(gna_pkg::KIND_CLEAR, 4'hf, 31'h7fffffff, 24'hffffff, 24'hffffff);
        send_word(gna_pkg::KIND_LOAD_JOB, 4'd3, 31'h7fffffff, 24'd0, 24'd0);
        send_word(gna_pkg::KIND_SOLVE, 4'd0, 31'd0, 24'd0, 24'd0);
    endtask

    task automatic test_extremes_and_ties();
        send_word(gna_pkg::KIND_CLEAR, 4'd0, 31'd0, 24'd0, 24'd0);
        // farthest possible pair
        send_word(gna_pkg::KIND_LOAD_ROBOT, 4'd0, 31'h7fffffff, 24'h800000, 24'h800000);
        send_word(gna_pkg::KIND_LOAD_JOB, 4'd15, 31'h7fffffff, 24'h7fffff, 24'h7fffff);
        send_word(gna_pkg::KIND_SOLVE, 4'd0, 31'd0, 24'd0, 24'd0);
        // reload overwrites; equal distances resolve by slot
        send_word(gna_pkg::KIND_LOAD_ROBOT, 4'd0, 31'd5, 24'd0, 24'd0);
        send_word(gna_pkg::KIND_LOAD_ROBOT, 4'd7, 31'd5, 24'd0, 24'd0);
        send_word(gna_pkg::KIND_LOAD_JOB, 4'd2, 31'd42, 24'd256, 24'd0);
        send_word(gna_pkg::KIND_LOAD_JOB, 4'd15, 31'd42, 24'hffff00, 24'd0);
        send_word(gna_pkg::KIND_LOAD_JOB, 4'd9, 31'd0, 24'd0, 24'd256);
        send_word(gna_pkg::KIND_SOLVE, 4'd0, 31'd0, 24'd0, 24'd0);
    endtask

    task automatic test_full_slots();
        send_word(gna_pkg::KIND_CLEAR, 4'd0, 31'd0, 24'd0, 24'd0);
        for (int s = 0; s < 16; s++) begin
            send_word(gna_pkg::KIND_LOAD_ROBOT, 4'(s), 31'($urandom), rand_coord(),
                      rand_coord());
            send_word(gna_pkg::KIND_LOAD_JOB, 4'(s), 31'($urandom), rand_coord(),
                      rand_coord());
        end
        send_word(gna_pkg::KIND_SOLVE, 4'd0, 31'd0, 24'd0, 24'd0);
        wait_drained();
    endtask

    // Mostly small load sets followed by a solve, sometimes a clear first
    task automatic test_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                send_word(gna_pkg::KIND_CLEAR, 4'($urandom), 31'($urandom), 24'($urandom),
                          24'($urandom));
                sent++;
            end
            repeat ($urandom_range(5)) begin
                send_word($urandom_range(1) ? gna_pkg::KIND_LOAD_JOB : gna_pkg::KIND_LOAD_ROBOT,
                          4'($urandom), 31'($urandom), rand_coord(), rand_coord());
                sent++;
            end
            send_word(gna_pkg::KIND_SOLVE, 4'($urandom), 31'($urandom), 24'($urandom),
                      24'($urandom));
            sent++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = gna_pkg::KIND_LOAD_ROBOT;
        solves_sent = 0;
        rob_here = '0;
        ord_here = '0;
        send_idle_pct = 23;
        recv_idle_pct = 79;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_solve();
        test_extremes_and_ties();
        test_full_slots();
        test_random(40);
        send_idle_pct = 79;
        recv_idle_pct = 23;
        test_random(40);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(40);
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d solves and %0d result words, with empty, full and tie cases.",
                 solves_sent, pairs_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/gna_pkg.sv
sv/gna_ctrl.sv
sv/gna_dp.sv
sv/greedy_nearest_assignment_unit.sv
bench/greedy_nearest_assignment_unit_tb.sv
